[sv/eoe_pkg.sv]
// ----------------------------------------------------------------------------
// eoe_pkg
// Shared types and fixed field widths for the event order enforcer.
// ----------------------------------------------------------------------------
package eoe_pkg;

    localparam int STEP_W    = 9;   // step pointer, sequence length, expected step
    localparam int TIMEOUT_W = 16;  // idle counter and timeout register
    localparam int RULE_W    = 6;   // signed requester rule
    localparam int ID_W      = 8;   // requester identity
    localparam int IDX_W     = 8;   // load position
    localparam int CODE_W    = 8;   // event code port width
    localparam int CFG_W     = 16;  // widest configuration register

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic {
        CFG_SEQ_LENGTH    = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } t_cfg_reg;

endpackage

[sv/eoe_seq_mem.sv]
// ----------------------------------------------------------------------------
// eoe_seq_mem
// Sequence entry store: one write port, one registered read port with
// write-to-read forwarding on an address match.
// ----------------------------------------------------------------------------
module eoe_seq_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // new data wins when the entry being read is written in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/eoe_bind.sv]
// ----------------------------------------------------------------------------
// eoe_bind
// Requester binding slots: evaluates a rule against a requester and binds
// an unbound slot on a granted positive rule.
// ----------------------------------------------------------------------------
module eoe_bind
    import eoe_pkg::*;
#(
    parameter int BIND_SLOTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [RULE_W-1:0] i_rule,
    input  logic [ID_W-1:0]          i_who,
    input  logic                     i_commit,
    output logic                     o_allow
);

    localparam int SW = (BIND_SLOTS > 1) ? $clog2(BIND_SLOTS) : 1;
    localparam logic [7:0] SLOTS_C = 8'(BIND_SLOTS);

    logic [BIND_SLOTS-1:0] r_valid;
    logic [ID_W-1:0]       r_id [BIND_SLOTS];

    logic [RULE_W-1:0] rule_u;
    logic [RULE_W-1:0] mag;
    logic [RULE_W-1:0] slot_full;
    logic [SW-1:0]     slot;
    logic              is_neg;
    logic              in_rng;
    logic              bound;
    logic              id_eq;
    logic              bind_wr;

    always_comb begin
        rule_u    = RULE_W'(i_rule);
        is_neg    = rule_u[RULE_W-1];
        mag       = is_neg ? RULE_W'(~rule_u + RULE_W'(1)) : rule_u;
        slot_full = RULE_W'(mag - RULE_W'(1));
        slot      = slot_full[SW-1:0];
        // zero rule or a slot beyond the table: anyone passes
        in_rng    = (rule_u != '0) && (8'(mag) <= SLOTS_C);
        bound     = in_rng && r_valid[slot];
        id_eq     = (r_id[slot] == i_who);
        if (!in_rng || !bound) begin
            o_allow = 1'b1;
        end else if (is_neg) begin
            o_allow = !id_eq;
        end else begin
            o_allow = id_eq;
        end
        bind_wr = i_commit && in_rng && !is_neg && !bound;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (bind_wr) begin
            r_valid[slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bind_wr) begin
            r_id[slot] <= i_who;
        end
    end

endmodule

[sv/event_order_enforcer_top.sv]
// ----------------------------------------------------------------------------
// event_order_enforcer_top
// Enforces a scripted order of events coming from many requesters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: load a
//   sequence entry, request an event, or an idle tick. Every item yields
//   exactly one result item on the output channel (o_out_valid /
//   i_out_ready) with grant, finished, deadlock and the next expected step.
//   Configuration (sequence length, timeout) is written through
//   i_cfg_we / i_cfg_index / i_cfg_data while no item is in flight.
// Timing:
//   An accepted item lands in the input register, is evaluated there once
//   the result register can take it, and its result is registered. One
//   item per cycle is sustained while results are taken; the current
//   entry is prefetched from the sequence memory using the next step
//   pointer, so a grant never costs a bubble.
// Reset:
//   Synchronous, active low. Step pointer, idle count, deadlock flag and
//   slot bindings clear; length resets to 0, timeout to 5. Sequence
//   entries are not cleared and must be loaded before use.
// Stall:
//   When the result register is full and not taken, evaluation stops and
//   one more item is held in the input register before o_in_ready drops.
// ----------------------------------------------------------------------------
module event_order_enforcer_top
    import eoe_pkg::*;
#(
    parameter int SEQ_DEPTH  = 256,
    parameter int BIND_SLOTS = 16,
    parameter int EVENT_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // input items
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_operation,
    input  logic [IDX_W-1:0]         i_step_index,
    input  logic [CODE_W-1:0]        i_event_code,
    input  logic signed [RULE_W-1:0] i_thread_rule,
    input  logic [ID_W-1:0]          i_requester,
    // result items
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_granted,
    output logic                     o_finished,
    output logic                     o_deadlock,
    output logic [STEP_W-1:0]        o_expected_step
);

    localparam int AW = $clog2(SEQ_DEPTH);
    localparam int EW = EVENT_BITS + RULE_W;   // entry: {event, rule}
    localparam int CW = AW + STEP_W + 1;       // compare width vs depth
    localparam logic [CW-1:0] DEPTH_C = CW'(SEQ_DEPTH);

    // configuration registers
    logic [STEP_W-1:0]    r_seq_len;
    logic [TIMEOUT_W-1:0] r_timeout;

    // input register
    logic                     r_in_valid;
    t_op                      r_op;
    logic [IDX_W-1:0]         r_idx;
    logic [CODE_W-1:0]        r_code;
    logic signed [RULE_W-1:0] r_rule;
    logic [ID_W-1:0]          r_who;

    // block state
    logic [STEP_W-1:0]    r_step;
    logic [TIMEOUT_W-1:0] r_idle;
    logic                 r_dead;

    // result register
    logic              r_out_valid;
    logic              r_out_granted;
    logic              r_out_finished;
    logic              r_out_deadlock;
    logic [STEP_W-1:0] r_out_step;

    // next values
    logic [STEP_W-1:0]    n_step;
    logic [TIMEOUT_W-1:0] n_idle;
    logic                 n_dead;
    logic                 n_finished;

    logic                     fire;
    logic                     done;
    logic                     ptr_in_rng;
    logic [EVENT_BITS-1:0]    code_ev;
    logic [EVENT_BITS+CODE_W-1:0] code_ext;
    logic [EW-1:0]            rd_data;
    logic [EVENT_BITS-1:0]    cur_event;
    logic signed [RULE_W-1:0] cur_rule;
    logic                     req_ok;
    logic                     allow;
    logic                     grant;
    logic                     tick;
    logic [TIMEOUT_W-1:0]     idle_inc;
    logic                     mem_we;
    logic [CW-1:0]            widx_ext;
    logic [CW-1:0]            step_ext;
    logic [CW-1:0]            nstep_ext;
    logic [AW-1:0]            waddr;
    logic [AW-1:0]            raddr;

    // ---------------- handshake ----------------
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= '0;
            r_timeout <= TIMEOUT_W'(5);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SEQ_LENGTH:    r_seq_len <= i_cfg_data[STEP_W-1:0];
                CFG_TIMEOUT_TICKS: r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                default:           r_timeout <= r_timeout;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op   <= t_op'(i_operation);
            r_idx  <= i_step_index;
            r_code <= i_event_code;
            r_rule <= i_thread_rule;
            r_who  <= i_requester;
        end
    end

    // ---------------- evaluation ----------------
    always_comb begin
        code_ext   = (EVENT_BITS + CODE_W)'(r_code);
        code_ev    = code_ext[EVENT_BITS-1:0];
        step_ext   = CW'(r_step);
        ptr_in_rng = step_ext < DEPTH_C;
        // finished: pointer reached the length, clipped to the memory depth
        done       = (r_step >= r_seq_len) || !ptr_in_rng;
        cur_event  = rd_data[EW-1:RULE_W];
        cur_rule   = rd_data[RULE_W-1:0];

        req_ok = fire && (r_op == OP_REQUEST) && !done && !r_dead &&
                 (cur_event == code_ev);
        grant  = req_ok && allow;
        tick   = fire && (r_op == OP_TICK) && !done && !r_dead;

        idle_inc = (r_idle != '1) ? TIMEOUT_W'(r_idle + TIMEOUT_W'(1)) : r_idle;

        n_step = grant ? STEP_W'(r_step + STEP_W'(1)) : r_step;
        if (grant) begin
            n_idle = '0;
        end else if (tick) begin
            n_idle = idle_inc;
        end else begin
            n_idle = r_idle;
        end
        n_dead = r_dead || (tick && (idle_inc >= r_timeout));

        nstep_ext  = CW'(n_step);
        n_finished = (n_step >= r_seq_len) || (nstep_ext >= DEPTH_C);

        // loads beyond the memory are dropped
        widx_ext = CW'(r_idx);
        mem_we   = fire && (r_op == OP_LOAD) && (widx_ext < DEPTH_C);
        waddr    = widx_ext[AW-1:0];
        raddr    = nstep_ext[AW-1:0];
    end

    // current entry is read at the next pointer, ready for the next item
    eoe_seq_mem #(
        .DEPTH (SEQ_DEPTH),
        .AW    (AW),
        .DW    (EW)
    ) u_seq_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata ({code_ev, RULE_W'(r_rule)}),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    eoe_bind #(
        .BIND_SLOTS (BIND_SLOTS)
    ) u_bind (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rule   (cur_rule),
        .i_who    (r_who),
        .i_commit (grant),
        .o_allow  (allow)
    );

    // ---------------- state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_idle <= '0;
            r_dead <= 1'b0;
        end else begin
            r_step <= n_step;
            r_idle <= n_idle;
            r_dead <= n_dead;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_granted  <= grant;
            r_out_finished <= n_finished;
            r_out_deadlock <= n_dead;
            r_out_step     <= n_step;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted       = r_out_granted;
    assign o_finished      = r_out_finished;
    assign o_deadlock      = r_out_deadlock;
    assign o_expected_step = r_out_step;

endmodule
